// ===== sv/tlvd_pkg.sv =====
// ----------------------------------------------------------------------------
// TLV deframer package
// Shared constants, codes and payload types of the TLV deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvd_pkg;

	// Header layout: type(16), version(16), length(32), request id(32).
	localparam int HEADER_BYTES = 12;
	localparam int HDR_LO_BYTES = 8;
	localparam int HDR_CNT_W    = 4;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 64;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_BODY   = 2'd1,
		KIND_REJECT = 2'd2
	} kind_e;

	typedef enum logic [1:0] {
		ERR_UNKNOWN_TYPE = 2'd0,
		ERR_BAD_VERSION  = 2'd1,
		ERR_TOO_LARGE    = 2'd2
	} err_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EXPECTED_VERSION = 2'd0,
		CFG_MAX_BODY_BYTES   = 2'd1,
		CFG_VALID_TYPE_MASK  = 2'd2
	} cfg_idx_e;

	typedef struct packed {
		logic [15:0] expected_version;
		logic [31:0] max_body_bytes;
		logic [63:0] valid_type_mask;
	} cfg_t;

	typedef struct packed {
		kind_e       kind;
		logic [15:0] msg_type;
		logic [31:0] request_id;
		logic [31:0] body_length;
		logic [7:0]  body_byte;
		err_e        error_code;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

// ===== sv/tlvd_rx_if.sv =====
// ----------------------------------------------------------------------------
// TLV deframer receive channel
// Valid/ready channel carrying one received byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlvd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/tlvd_res_if.sv =====
// ----------------------------------------------------------------------------
// TLV deframer result channel
// Valid/ready channel carrying one decoded result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlvd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] msg_type;
	logic [31:0] request_id;
	logic [31:0] body_length;
	logic [7:0]  body_byte;
	logic [1:0]  error_code;
	logic        last;

	modport source (
		output valid, output kind, output msg_type, output request_id,
		output body_length, output body_byte, output error_code, output last,
		input ready
	);
	modport sink (
		input valid, input kind, input msg_type, input request_id,
		input body_length, input body_byte, input error_code, input last,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/tlvd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// TLV deframer configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlvd_cfg_if;
	import tlvd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== sv/tlvd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// TLV deframer configuration registers
// Holds version, maximum body length and the known-type bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvd_cfg_regs (
	input  wire            clk,
	input  wire            arst_n,
	tlvd_cfg_if.sink       cfg,
	output tlvd_pkg::cfg_t regs
);
	import tlvd_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.expected_version <= 16'd1;
			regs_q.max_body_bytes   <= 32'd65536;
			regs_q.valid_type_mask  <= '0;
		end else if (cfg.valid) begin
			// Writes to an index beyond the register list are dropped.
			case (cfg_idx_e'(cfg.index))
				CFG_EXPECTED_VERSION: regs_q.expected_version <= cfg.wdata[15:0];
				CFG_MAX_BODY_BYTES:   regs_q.max_body_bytes   <= cfg.wdata[31:0];
				CFG_VALID_TYPE_MASK:  regs_q.valid_type_mask  <= cfg.wdata;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/tlvd_parse.sv =====
// ----------------------------------------------------------------------------
// TLV deframer parser
// Collects the header, runs the header checks and passes body bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvd_parse (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            accept,
	input  wire [7:0]      rx_byte,
	input  tlvd_pkg::cfg_t regs,
	output logic           res_valid,
	output tlvd_pkg::res_t res
);
	import tlvd_pkg::*;

	logic                 in_body_q, in_body_d;
	logic [HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
	logic [63:0]          hdr_lo_q, hdr_lo_d;
	logic [31:0]          hdr_hi_q, hdr_hi_d;
	logic [31:0]          body_rem_q, body_rem_d;
	logic [31:0]          rem_dec;
	logic [15:0]          h_type;
	logic [15:0]          h_version;
	logic [31:0]          h_length;
	logic                 type_known;

	assign rem_dec    = body_rem_q - 32'd1;
	assign h_type     = hdr_lo_d[63:48];
	assign h_version  = hdr_lo_d[47:32];
	assign h_length   = hdr_lo_d[31:0];
	assign type_known = (h_type[15:6] == 10'd0) && regs.valid_type_mask[h_type[5:0]];

	always_comb begin
		in_body_d  = in_body_q;
		hdr_cnt_d  = hdr_cnt_q;
		hdr_lo_d   = hdr_lo_q;
		hdr_hi_d   = hdr_hi_q;
		body_rem_d = body_rem_q;
		res_valid  = 1'b0;
		if (accept && !in_body_q) begin
			if (hdr_cnt_q < HDR_CNT_W'(HDR_LO_BYTES)) begin
				hdr_lo_d = {hdr_lo_q[55:0], rx_byte};
			end else begin
				hdr_hi_d = {hdr_hi_q[23:0], rx_byte};
			end
			hdr_cnt_d = hdr_cnt_q + HDR_CNT_W'(1);
		end

		res.kind        = KIND_BODY;
		res.msg_type    = h_type;
		res.request_id  = hdr_hi_d;
		res.body_length = h_length;
		res.body_byte   = 8'd0;
		res.error_code  = ERR_UNKNOWN_TYPE;
		res.last        = 1'b0;

		if (accept) begin
			if (in_body_q) begin
				res_valid      = 1'b1;
				res.body_byte  = rx_byte;
				res.last       = (rem_dec == 32'd0);
				body_rem_d     = rem_dec;
				if (rem_dec == 32'd0) begin
					in_body_d = 1'b0;
					hdr_cnt_d = '0;
				end
			end else if (hdr_cnt_q == HDR_CNT_W'(HEADER_BYTES - 1)) begin
				res_valid = 1'b1;
				hdr_cnt_d = '0;
				if (!type_known) begin
					res.kind       = KIND_REJECT;
					res.error_code = ERR_UNKNOWN_TYPE;
					res.last       = 1'b1;
				end else if (h_version != regs.expected_version) begin
					res.kind       = KIND_REJECT;
					res.error_code = ERR_BAD_VERSION;
					res.last       = 1'b1;
				end else if (h_length > regs.max_body_bytes) begin
					res.kind       = KIND_REJECT;
					res.error_code = ERR_TOO_LARGE;
					res.last       = 1'b1;
				end else begin
					res.kind   = KIND_HEADER;
					res.last   = (h_length == 32'd0);
					body_rem_d = h_length;
					in_body_d  = (h_length != 32'd0);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q  <= 1'b0;
			hdr_cnt_q  <= '0;
			hdr_lo_q   <= '0;
			hdr_hi_q   <= '0;
			body_rem_q <= '0;
		end else begin
			in_body_q  <= in_body_d;
			hdr_cnt_q  <= hdr_cnt_d;
			hdr_lo_q   <= hdr_lo_d;
			hdr_hi_q   <= hdr_hi_d;
			body_rem_q <= body_rem_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/tlvd_out_buf.sv =====
// ----------------------------------------------------------------------------
// TLV deframer output buffer
// Result register with a skid stage, so the receive side keeps full rate while results are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvd_out_buf (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  tlvd_pkg::res_t push_res,
	output logic           room,
	tlvd_res_if.source     res
);
	import tlvd_pkg::*;

	logic out_vld_q;
	logic skid_vld_q;
	res_t out_q;
	res_t skid_q;
	logic pop;

	assign pop  = out_vld_q && res.ready;
	// A push only happens while the skid stage is empty.
	assign room = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || pop) begin
			out_vld_q  <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || pop) begin
			out_q <= skid_vld_q ? skid_q : push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	assign res.valid       = out_vld_q;
	assign res.kind        = out_q.kind;
	assign res.msg_type    = out_q.msg_type;
	assign res.request_id  = out_q.request_id;
	assign res.body_length = out_q.body_length;
	assign res.body_byte   = out_q.body_byte;
	assign res.error_code  = out_q.error_code;
	assign res.last        = out_q.last;

endmodule

`default_nettype wire

// ===== sv/tlv_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// TLV frame deframer
// Splits a byte stream into checked headers and passed-through body bytes.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock while the output stage has
// room. Twelve header bytes (type, version, body length, request id, all
// big-endian) produce no result until the last one arrives; that byte yields
// a header result or a rejection with an error code. After a header result
// each body byte yields one result and the final one is marked last. Each
// result is registered into a two-entry output stage (result register plus
// skid register) that decouples the sides, so input stalls only once two
// results are waiting; with the result side always ready the rate is one
// byte per cycle. Configuration writes are always accepted and take effect
// for headers finished after them.
`default_nettype none

module tlv_frame_deframer (
	input  wire   clk,
	input  wire   arst_n,
	tlvd_rx_if.sink    rx,
	tlvd_res_if.source res,
	tlvd_cfg_if.sink   cfg
);
	import tlvd_pkg::*;

	cfg_t regs;
	res_t parse_res;
	logic parse_vld;
	logic room;
	logic accept;

	assign rx.ready = room;
	assign accept   = rx.valid && room;

	tlvd_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	tlvd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx.rx_byte),
		.regs      (regs),
		.res_valid (parse_vld),
		.res       (parse_res)
	);

	tlvd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (parse_vld),
		.push_res (parse_res),
		.room     (room),
		.res      (res)
	);

endmodule

`default_nettype wire
